### hdl/epc_pkg.sv
package epc_pkg;

   localparam int CHUNK_SLOTS_DEF = 4096;
   localparam int MAX_TERMS_DEF   = 7;
   localparam int GEN_BITS_DEF    = 16;

   localparam int CMD_W       = 2;
   localparam int TERM_W      = 3;
   localparam int RAW_W       = 24;
   localparam int POS_W       = 25;
   localparam int ADJ_W       = 26;
   localparam int DIFF_W      = 27;
   localparam int OFF_W       = 8;
   localparam int CNT_W       = 3;
   localparam int FREQ_W      = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int REQ_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   typedef logic        [TERM_W-1:0]    term_type;
   typedef logic        [CNT_W-1:0]     cnt_type;
   typedef logic        [RAW_W-1:0]     raw_type;
   typedef logic signed [OFF_W-1:0]     off_type;
   typedef logic signed [POS_W-1:0]     pos_type;
   typedef logic signed [ADJ_W-1:0]     adj_type;
   typedef logic signed [DIFF_W-1:0]    diff_type;
   typedef logic        [FREQ_W-1:0]    freq_type;
   typedef logic        [CSR_IDX_W-1:0] csr_idx_type;
   typedef logic        [QCOUNT_W-1:0]  qcount_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_BEGIN_DOC   = 2'd0,
      CMD_BEGIN_CHUNK = 2'd1,
      CMD_TERM_POS    = 2'd2,
      CMD_END_DOC     = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      OP_DOC_BEGIN,
      OP_WRAP,
      OP_MARK,
      OP_ADVANCE,
      OP_FINAL,
      OP_EMIT
   } op_kind_type;

   typedef enum logic {
      BK_RUN,
      BK_CLEAR
   } back_state_type;

   localparam csr_idx_type REG_NUM_TERMS = 3'd0;
   localparam term_type    MIN_TERMS     = 3'd2;

endpackage

### hdl/epc_queue.sv
module epc_queue #(
   parameter int W = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [W-1:0]                  push_data,
   input  logic                          pop,
   output logic [W-1:0]                  pop_data,
   output logic                          empty,
   output logic [epc_pkg::QCOUNT_W-1:0] count
);

   localparam int PTR_W = $clog2(epc_pkg::QUEUE_DEPTH);

   logic [W-1:0]                  entry_ff [epc_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]              wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]              rd_ptr_ff, rd_ptr_in;
   logic [epc_pkg::QCOUNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = entry_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

endmodule

### hdl/epc_front.sv
module epc_front #(
   parameter  int CHUNK_SLOTS = epc_pkg::CHUNK_SLOTS_DEF,
   parameter  int MAX_TERMS   = epc_pkg::MAX_TERMS_DEF,
   parameter  int GEN_BITS    = epc_pkg::GEN_BITS_DEF,
   localparam int SLOT_W      = $clog2(CHUNK_SLOTS),
   localparam int OP_W        = $bits(epc_pkg::op_kind_type) + SLOT_W + GEN_BITS
                                + epc_pkg::TERM_W
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [epc_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [epc_pkg::CMD_W-1:0]          req_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [epc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [epc_pkg::OFF_W-1:0]          csr_data,
   input  logic [epc_pkg::QCOUNT_W-1:0]       q_count,
   input  logic                               init_busy,
   output logic                               push,
   output logic [OP_W-1:0]                    push_op
);

   localparam int TIDX_W = $clog2(MAX_TERMS);

   typedef struct packed {
      epc_pkg::op_kind_type kind;
      logic [SLOT_W-1:0]    slot;
      logic [GEN_BITS-1:0]  gen;
      epc_pkg::term_type    term;
   } op_type;

   // configuration
   epc_pkg::term_type num_terms_ff;
   epc_pkg::off_type  offs_ff [MAX_TERMS];

   // request register
   logic              f1_valid_ff;
   epc_pkg::cmd_type  f1_cmd_ff;
   epc_pkg::term_type f1_term_ff;
   epc_pkg::adj_type  f1_pos_ff;
   logic              f1_ok_ff;

   // document state
   epc_pkg::pos_type     base_ff, base_in;
   logic [GEN_BITS-1:0]  gen_ff, gen_in;
   logic [GEN_BITS-1:0]  gen_inc;
   epc_pkg::adj_type     last_ff [MAX_TERMS];
   epc_pkg::adj_type     last_in [MAX_TERMS];

   logic                 accept;
   epc_pkg::cmd_type     in_cmd;
   epc_pkg::term_type    in_term;
   epc_pkg::raw_type     in_raw;
   epc_pkg::off_type     off_sel;
   epc_pkg::adj_type     in_pos;
   epc_pkg::term_type    n_eff;
   epc_pkg::adj_type     last_sel;
   epc_pkg::diff_type    diff;
   logic                 newer;
   logic                 in_range;
   logic [TIDX_W-1:0]    f1_tix;
   op_type               op;

   assign csr_ready = 1'b1;

   // one slot held back for the request sitting in the request register
   assign req_tready = !init_busy
                       && (q_count <= epc_pkg::qcount_type'(epc_pkg::QUEUE_DEPTH - 2));
   assign accept     = req_tvalid && req_tready;

   assign in_cmd  = epc_pkg::cmd_type'(req_tuser);
   assign in_term = req_tdata[epc_pkg::TERM_W-1:0];
   assign in_raw  = req_tdata[epc_pkg::TERM_W +: epc_pkg::RAW_W];

   always_comb begin
      n_eff = (num_terms_ff < epc_pkg::MIN_TERMS) ? epc_pkg::MIN_TERMS : num_terms_ff;
      if (n_eff > epc_pkg::term_type'(MAX_TERMS)) begin
         n_eff = epc_pkg::term_type'(MAX_TERMS);
      end
   end

   // adjusted position can run past the top of the raw range with a positive offset
   always_comb begin
      off_sel = '0;
      if (in_term < epc_pkg::term_type'(MAX_TERMS)) begin
         off_sel = offs_ff[in_term[TIDX_W-1:0]];
      end
      in_pos = epc_pkg::adj_type'({2'b0, in_raw}) + epc_pkg::adj_type'(off_sel);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_terms_ff <= epc_pkg::MIN_TERMS;
         for (int i = 0; i < MAX_TERMS; i++) begin
            offs_ff[i] <= epc_pkg::off_type'(-i);
         end
      end else if (csr_valid) begin
         if (csr_index == epc_pkg::REG_NUM_TERMS) begin
            num_terms_ff <= csr_data[epc_pkg::TERM_W-1:0];
         end
         for (int i = 0; i < MAX_TERMS; i++) begin
            if (csr_index == epc_pkg::csr_idx_type'(i + 1)) begin
               offs_ff[i] <= csr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f1_cmd_ff  <= in_cmd;
         f1_term_ff <= in_term;
         f1_pos_ff  <= in_pos;
         f1_ok_ff   <= (in_term < n_eff);
      end
   end

   // classify: dedupe against the term's last position, locate the slot
   assign f1_tix   = f1_term_ff[TIDX_W-1:0];
   assign last_sel = f1_ok_ff ? last_ff[f1_tix] : '0;
   assign newer    = (f1_pos_ff > last_sel);
   assign diff     = epc_pkg::diff_type'(f1_pos_ff) - epc_pkg::diff_type'(base_ff);
   assign in_range = !diff[epc_pkg::DIFF_W-1]
                     && (diff < epc_pkg::diff_type'(CHUNK_SLOTS));
   assign gen_inc  = gen_ff + 1'b1;

   always_comb begin
      base_in = base_ff;
      gen_in  = gen_ff;
      last_in = last_ff;
      push    = 1'b0;
      op.kind = epc_pkg::OP_EMIT;
      op.slot = diff[SLOT_W-1:0];
      op.gen  = gen_ff;
      op.term = f1_term_ff;
      if (f1_valid_ff) begin
         case (f1_cmd_ff)
            epc_pkg::CMD_BEGIN_DOC: begin
               base_in = epc_pkg::pos_type'(-CHUNK_SLOTS);
               for (int i = 0; i < MAX_TERMS; i++) begin
                  last_in[i] = '1;
               end
               push    = 1'b1;
               op.kind = epc_pkg::OP_DOC_BEGIN;
            end
            epc_pkg::CMD_BEGIN_CHUNK: begin
               base_in = base_ff + epc_pkg::pos_type'(CHUNK_SLOTS);
               if (gen_inc == '0) begin
                  // generation wrapped: back end sweeps the slot table
                  gen_in  = {{(GEN_BITS-1){1'b0}}, 1'b1};
                  push    = 1'b1;
                  op.kind = epc_pkg::OP_WRAP;
               end else begin
                  gen_in = gen_inc;
               end
            end
            epc_pkg::CMD_TERM_POS: begin
               if (f1_ok_ff && newer) begin
                  last_in[f1_tix] = f1_pos_ff;
                  if (in_range) begin
                     push = 1'b1;
                     if (f1_term_ff == '0) begin
                        op.kind = epc_pkg::OP_MARK;
                     end else if (f1_term_ff == n_eff - 1'b1) begin
                        op.kind = epc_pkg::OP_FINAL;
                     end else begin
                        op.kind = epc_pkg::OP_ADVANCE;
                     end
                  end
               end
            end
            epc_pkg::CMD_END_DOC: begin
               push    = 1'b1;
               op.kind = epc_pkg::OP_EMIT;
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
   end

   assign push_op = op;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         gen_ff  <= '0;
         for (int i = 0; i < MAX_TERMS; i++) begin
            last_ff[i] <= '1;
         end
      end else begin
         base_ff <= base_in;
         gen_ff  <= gen_in;
         last_ff <= last_in;
      end
   end

endmodule

### hdl/epc_back.sv
module epc_back #(
   parameter  int CHUNK_SLOTS = epc_pkg::CHUNK_SLOTS_DEF,
   parameter  int GEN_BITS    = epc_pkg::GEN_BITS_DEF,
   localparam int SLOT_W      = $clog2(CHUNK_SLOTS),
   localparam int OP_W        = $bits(epc_pkg::op_kind_type) + SLOT_W + GEN_BITS
                                + epc_pkg::TERM_W
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_empty,
   input  logic [OP_W-1:0]                q_data,
   output logic                           q_pop,
   output logic                           init_busy,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [epc_pkg::FREQ_W-1:0]     rsp_tdata
);

   typedef struct packed {
      epc_pkg::op_kind_type kind;
      logic [SLOT_W-1:0]    slot;
      logic [GEN_BITS-1:0]  gen;
      epc_pkg::term_type    term;
   } op_type;

   typedef struct packed {
      logic [GEN_BITS-1:0] gen;
      epc_pkg::cnt_type    cnt;
   } entry_type;

   entry_type mem [CHUNK_SLOTS];

   epc_pkg::back_state_type state_ff, state_in;
   logic [SLOT_W-1:0]       sweep_ff, sweep_in;
   logic                    init_ff, init_in;

   logic              b_valid_ff;
   op_type            b_op_ff;
   entry_type         rd_q_ff;
   logic              fwd_valid_ff;
   logic [SLOT_W-1:0] fwd_slot_ff;
   entry_type         fwd_data_ff;
   epc_pkg::freq_type total_ff, total_in;
   logic              rsp_valid_ff, rsp_valid_in;
   epc_pkg::freq_type rsp_data_ff;

   op_type            head;
   logic              emit_block;
   logic              clr_we;
   entry_type         rd;
   logic              hit;
   logic              b_we;
   entry_type         b_wdata;
   logic              b_emit;
   logic              we;
   logic [SLOT_W-1:0] waddr;
   entry_type         wdata;

   assign head = op_type'(q_data);

   // an end-document request waits until the output register is sure to be free
   assign emit_block = (head.kind == epc_pkg::OP_EMIT)
                       && ((rsp_valid_ff && !rsp_tready)
                           || (b_valid_ff && b_op_ff.kind == epc_pkg::OP_EMIT));

   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      init_in  = init_ff;
      q_pop    = 1'b0;
      clr_we   = 1'b0;
      case (state_ff)
         epc_pkg::BK_RUN: begin
            if (!q_empty && !emit_block) begin
               q_pop = 1'b1;
               if (head.kind == epc_pkg::OP_WRAP) begin
                  state_in = epc_pkg::BK_CLEAR;
                  sweep_in = '0;
               end
            end
         end
         epc_pkg::BK_CLEAR: begin
            clr_we   = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == SLOT_W'(CHUNK_SLOTS - 1)) begin
               state_in = epc_pkg::BK_RUN;
               sweep_in = '0;
               init_in  = 1'b0;
            end
         end
         default: begin
            state_in = epc_pkg::BK_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= epc_pkg::BK_CLEAR;
         sweep_ff <= '0;
         init_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         init_ff  <= init_in;
      end
   end

   assign init_busy = init_ff;

   // read data misses the write made on the same edge; take it from the bypass
   assign rd  = (fwd_valid_ff && fwd_slot_ff == b_op_ff.slot) ? fwd_data_ff : rd_q_ff;
   assign hit = (rd.gen == b_op_ff.gen) && (rd.cnt == b_op_ff.term);

   always_comb begin
      b_we     = 1'b0;
      b_wdata  = rd;
      b_emit   = 1'b0;
      total_in = total_ff;
      if (b_valid_ff) begin
         case (b_op_ff.kind)
            epc_pkg::OP_DOC_BEGIN: begin
               total_in = '0;
            end
            epc_pkg::OP_MARK: begin
               b_we        = 1'b1;
               b_wdata.gen = b_op_ff.gen;
               b_wdata.cnt = epc_pkg::cnt_type'(1);
            end
            epc_pkg::OP_ADVANCE: begin
               b_we        = hit;
               b_wdata.cnt = rd.cnt + 1'b1;
            end
            epc_pkg::OP_FINAL: begin
               if (hit && total_ff != '1) begin
                  total_in = total_ff + 1'b1;
               end
            end
            epc_pkg::OP_EMIT: begin
               b_emit = 1'b1;
            end
            default: begin
               b_we = 1'b0;
            end
         endcase
      end
   end

   assign we    = clr_we || b_we;
   assign waddr = clr_we ? sweep_ff : b_op_ff.slot;
   assign wdata = clr_we ? entry_type'('0) : b_wdata;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_q_ff <= mem[head.slot];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         fwd_valid_ff <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= q_pop;
         fwd_valid_ff <= we;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         b_op_ff <= head;
      end
      fwd_slot_ff <= waddr;
      fwd_data_ff <= wdata;
      if (b_emit) begin
         rsp_data_ff <= total_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (b_emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### hdl/exact_phrase_position_counter.sv
// Channel   Direction  Handshake               Payload
// req_      in         req_tvalid/req_tready   tuser: cmd; tdata: term_index, position
// rsp_      out        rsp_tvalid/rsp_tready   tdata: phrase_freq
// csr_      in         csr_valid/csr_ready     csr_index, csr_data
//
// One request per cycle sustained while the queue has room; each term position
// is one read-modify-write of the chunk slot table, which has one read and one
// write port. An end-document request's count passes the request register, the
// queue, the back-end and the output register; one that directly follows another
// end-document request waits in the queue. After reset the slot table is swept
// with req_tready low. A generation wrap sweeps it again; requests fill the queue.
module exact_phrase_position_counter #(
   parameter int CHUNK_SLOTS = epc_pkg::CHUNK_SLOTS_DEF,
   parameter int MAX_TERMS   = epc_pkg::MAX_TERMS_DEF,
   parameter int GEN_BITS    = epc_pkg::GEN_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [2:0] term_index, [26:3] position, [31:27] zero
   input  logic [epc_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [1:0] cmd
   input  logic [epc_pkg::CMD_W-1:0]       req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [15:0] phrase_freq
   output logic [epc_pkg::FREQ_W-1:0]      rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [epc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [epc_pkg::OFF_W-1:0]       csr_data
);

   localparam int SLOT_W = $clog2(CHUNK_SLOTS);
   localparam int OP_W   = $bits(epc_pkg::op_kind_type) + SLOT_W + GEN_BITS
                           + epc_pkg::TERM_W;

   logic                          push;
   logic [OP_W-1:0]               push_op;
   logic                          q_pop;
   logic [OP_W-1:0]               q_data;
   logic                          q_empty;
   logic [epc_pkg::QCOUNT_W-1:0] q_count;
   logic                          init_busy;

   epc_front #(
      .CHUNK_SLOTS (CHUNK_SLOTS),
      .MAX_TERMS   (MAX_TERMS),
      .GEN_BITS    (GEN_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .q_count    (q_count),
      .init_busy  (init_busy),
      .push       (push),
      .push_op    (push_op)
   );

   epc_queue #(
      .W (OP_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_op),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty),
      .count     (q_count)
   );

   epc_back #(
      .CHUNK_SLOTS (CHUNK_SLOTS),
      .GEN_BITS    (GEN_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .init_busy  (init_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### hdl/epc_checker.sv
module epc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [epc_pkg::FREQ_W-1:0] rsp_tdata,
   input logic                       csr_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped or changed while stalled");

   // slot table sweep keeps requests out right after reset
   a_init_gate: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken during slot table sweep");

   a_no_early_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid ##1 !rsp_tvalid)
      else $error("response without a request after reset");

   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("config port not ready");

endmodule

bind exact_phrase_position_counter epc_checker u_epc_checker (.*);

### tb/exact_phrase_position_counter_test.sv
module exact_phrase_position_counter_test;
   import epc_pkg::*;

   localparam int SLOTS = CHUNK_SLOTS_DEF;
   localparam int TERMS = MAX_TERMS_DEF;
   localparam int TERM_MAX = (1 << TERM_W) - 1;
   localparam int IDLE_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam csr_idx_type REG_OFFSET_TERM0 = 3'd1;
   localparam raw_type RAW_MAX = '1;

   typedef logic [GEN_BITS_DEF-1:0] gen_type;

   typedef struct packed {
      cmd_type  cmd;
      term_type term;
      raw_type  raw;
      logic     typed;
      freq_type freq;
   } step_row;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [FREQ_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [OFF_W-1:0] csr_data = '0;

   exact_phrase_position_counter dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   // phrase matcher state, as the block should hold it
   cnt_type slot_mark_count [SLOTS];
   gen_type slot_mark_gen [SLOTS];
   gen_type cur_gen = '0;
   pos_type cur_base = '0;
   int last_adj_pos [TERMS];
   freq_type doc_matches = '0;
   cnt_type set_terms = MIN_TERMS;
   off_type set_offset [TERMS];

   cnt_type plan_terms;
   off_type plan_offset [TERMS];

   freq_type pending_freq [$];
   freq_type oldest_freq;
   int mismatch_count = 0;
   int requests_sent = 0;
   int freqs_checked = 0;
   int idle_cycles = 0;
   bit calm = 1'b0;

   // reset config: two terms, term t at phrase position t
   step_row script [22] = '{
      '{CMD_END_DOC,     3'd0, 24'd0,        1'b1, 16'd0},
      '{CMD_BEGIN_DOC,   3'd0, 24'd0,        1'b0, 16'd0},
      '{CMD_BEGIN_CHUNK, 3'd0, 24'd0,        1'b0, 16'd0},
      '{CMD_TERM_POS,    3'd0, 24'd5,        1'b0, 16'd0},
      '{CMD_TERM_POS,    3'd0, 24'd5,        1'b0, 16'd0},
      '{CMD_TERM_POS,    3'd0, 24'd4095,     1'b0, 16'd0},
      '{CMD_TERM_POS,    3'd0, 24'd4096,     1'b0, 16'd0},
      '{CMD_TERM_POS,    3'd1, 24'd0,        1'b0, 16'd0},
      '{CMD_TERM_POS,    3'd1, 24'd6,        1'b0, 16'd0},
      '{CMD_TERM_POS,    3'd1, 24'd6,        1'b0, 16'd0},
      '{CMD_TERM_POS,    3'd1, 24'd4096,     1'b0, 16'd0},
      '{CMD_TERM_POS,    3'd2, 24'd100,      1'b0, 16'd0},
      '{CMD_TERM_POS,    3'd7, 24'hFFFFFF,   1'b0, 16'd0},
      '{CMD_END_DOC,     3'd0, 24'd0,        1'b1, 16'd2},
      '{CMD_BEGIN_DOC,   3'd0, 24'd0,        1'b0, 16'd0},
      '{CMD_BEGIN_CHUNK, 3'd0, 24'd0,        1'b0, 16'd0},
      '{CMD_TERM_POS,    3'd0, 24'd0,        1'b0, 16'd0},
      '{CMD_TERM_POS,    3'd1, 24'd1,        1'b0, 16'd0},
      '{CMD_TERM_POS,    3'd1, 24'd6,        1'b0, 16'd0},
      '{CMD_TERM_POS,    3'd0, 24'hFFFFFF,   1'b0, 16'd0},
      '{CMD_TERM_POS,    3'd1, 24'hFFFFFF,   1'b0, 16'd0},
      '{CMD_END_DOC,     3'd0, 24'd0,        1'b1, 16'd1}
   };

   function automatic int effective_terms();
      return (set_terms < MIN_TERMS) ? int'(MIN_TERMS) : int'(set_terms);
   endfunction

   task automatic track_request(input cmd_type cmd, input term_type t, input raw_type raw,
                                output logic emits, output freq_type freq);
      int adj;
      int slot;
      emits = 1'b0;
      freq = '0;
      case (cmd)
         CMD_BEGIN_DOC: begin
            doc_matches = '0;
            foreach (last_adj_pos[i]) last_adj_pos[i] = -1;
            // first chunk of the document then lands on base zero
            cur_base = pos_type'(-SLOTS);
         end
         CMD_BEGIN_CHUNK: begin
            cur_base = cur_base + pos_type'(SLOTS);
            cur_gen = cur_gen + 1'b1;
            if (cur_gen == '0) begin
               foreach (slot_mark_gen[i]) slot_mark_gen[i] = '0;
               cur_gen = 1;
            end
         end
         CMD_TERM_POS: begin
            if (int'(t) < effective_terms()) begin
               adj = int'(raw) + int'(set_offset[t]);
               if (adj > last_adj_pos[t]) begin
                  last_adj_pos[t] = adj;
                  slot = adj - int'(cur_base);
                  if (slot >= 0 && slot < SLOTS) begin
                     if (t == 0) begin
                        slot_mark_count[slot] = 1;
                        slot_mark_gen[slot] = cur_gen;
                     end else if (slot_mark_gen[slot] == cur_gen &&
                                  slot_mark_count[slot] == cnt_type'(t)) begin
                        if (int'(t) < effective_terms() - 1)
                           slot_mark_count[slot] = slot_mark_count[slot] + 1'b1;
                        else if (doc_matches != '1)
                           doc_matches = doc_matches + 1'b1;
                     end
                  end
               end
            end
         end
         CMD_END_DOC: begin
            emits = 1'b1;
            freq = doc_matches;
         end
      endcase
   endtask

   task automatic send(input cmd_type cmd, input term_type t = '0, input raw_type raw = '0,
                       input logic typed = 1'b0, input freq_type want = '0);
      logic emits;
      freq_type freq;
      if (!calm) begin
         while ($urandom_range(99) < 24) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {5'b0, raw, t};
      do @(posedge clock); while (!req_tready);
      requests_sent++;
      track_request(cmd, t, raw, emits, freq);
      if (emits) pending_freq.push_back(typed ? want : freq);
   endtask

   task automatic send_term(input int t, input int raw);
      if (raw >= 0 && raw <= int'(RAW_MAX))
         send(CMD_TERM_POS, term_type'(t), raw_type'(raw));
   endtask

   task automatic csr_write(input csr_idx_type idx, input logic [OFF_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic write_settings();
      csr_write(REG_NUM_TERMS, OFF_W'(plan_terms));
      for (int t = 0; t < TERMS; t++)
         csr_write(REG_OFFSET_TERM0 + csr_idx_type'(t), plan_offset[t]);
      csr_valid <= 1'b0;
      set_terms = plan_terms;
      foreach (set_offset[t]) set_offset[t] = plan_offset[t];
   endtask

   // wait for every count, then let trailing term requests drain
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_freq.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // well-formed document: each chunk plants phrase starts, then walks the terms
   task automatic send_document();
      int n;
      int base;
      int p;
      int want;
      int starts [$];
      n = effective_terms();
      send(CMD_BEGIN_DOC);
      repeat ($urandom_range(1, 3)) begin
         if ($urandom_range(4) == 0)
            repeat ($urandom_range(1, 4)) send(CMD_BEGIN_CHUNK);
         send(CMD_BEGIN_CHUNK);
         base = int'(cur_base);
         starts.delete();
         want = $urandom_range(0, 8);
         p = ($urandom_range(3) == 0) ? int'($urandom_range(0, 40)) - 20
                                      : int'($urandom_range(0, 3500));
         while (starts.size() < want && p < SLOTS + 14) begin
            starts.push_back(p);
            p = p + int'($urandom_range(1, 400));
         end
         if ($urandom_range(5) == 0 && (starts.size() == 0 || starts[$] < SLOTS - 1))
            starts.push_back(SLOTS - 1);
         for (int t = 0; t < n; t++) begin
            foreach (starts[i]) begin
               if ($urandom_range(99) < 88) begin
                  send_term(t, base + starts[i] - int'(set_offset[t]));
                  if ($urandom_range(19) == 0)
                     send_term(t, base + starts[i] - int'(set_offset[t]));
               end
            end
         end
         if ($urandom_range(9) == 0)
            send_term($urandom_range(n, TERM_MAX), $urandom_range(0, int'(RAW_MAX)));
      end
      send(CMD_END_DOC);
   endtask

   task automatic send_scramble();
      repeat ($urandom_range(5, 40)) begin
         case ($urandom_range(9))
            0: send(CMD_BEGIN_DOC);
            1: send(CMD_BEGIN_CHUNK);
            2: send(CMD_END_DOC);
            default: begin
               if ($urandom_range(1) == 0)
                  send(CMD_TERM_POS, term_type'($urandom_range(0, TERM_MAX)),
                       raw_type'($urandom));
               else
                  send(CMD_TERM_POS, term_type'($urandom_range(0, TERM_MAX)),
                       raw_type'(int'(cur_base) + int'($urandom_range(0, SLOTS + 256)) - 128));
            end
         endcase
      end
      send(CMD_END_DOC);
   endtask

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 24);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_freq.size() == 0) begin
            $error("phrase_freq: unexpected result %0d", rsp_tdata);
            mismatch_count++;
         end else begin
            oldest_freq = pending_freq.pop_front();
            freqs_checked++;
            if (rsp_tdata !== oldest_freq) begin
               $error("phrase_freq: expected %0d, got %0d", oldest_freq, rsp_tdata);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int phase;
      int first_random;
      foreach (slot_mark_count[i]) begin
         slot_mark_count[i] = '0;
         slot_mark_gen[i] = '0;
      end
      foreach (last_adj_pos[t]) begin
         last_adj_pos[t] = -1;
         set_offset[t] = off_type'(-t);
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // a chunk begin comes before the first term, so the generation is never zero when a
      // later term reads a slot count
      foreach (script[i])
         send(script[i].cmd, script[i].term, script[i].raw, script[i].typed, script[i].freq);

      // run the generation around; slots marked in the first two chunks must not match
      send(CMD_BEGIN_DOC);
      while (cur_gen != '1) send(CMD_BEGIN_CHUNK);
      send(CMD_BEGIN_DOC);
      send(CMD_BEGIN_CHUNK);
      send_term(0, 100);
      send_term(1, 6);
      send_term(1, 101);
      send_term(1, SLOTS);
      send(CMD_END_DOC);

      // every slot of 16 chunks matches: one more than the count can hold
      calm = 1'b1;
      send(CMD_BEGIN_DOC);
      for (int c = 0; c < 16; c++) begin
         if (c == 4) calm = 1'b0;
         send(CMD_BEGIN_CHUNK);
         for (int s = 0; s < SLOTS; s++) send_term(0, int'(cur_base) + s);
         for (int s = 0; s < SLOTS; s++) send_term(1, int'(cur_base) + s + 1);
      end
      send(CMD_END_DOC);
      settle();

      phase = 0;
      first_random = requests_sent;
      while (requests_sent - first_random < RANDOM_ITEMS) begin
         plan_terms = cnt_type'($urandom_range(0, 7));
         foreach (plan_offset[t])
            plan_offset[t] = ($urandom_range(9) == 0) ? off_type'($urandom)
                                                      : off_type'(-int'($urandom_range(0, 127)));
         case (phase)
            0: begin
               plan_terms = 3'd7;
               foreach (plan_offset[t]) plan_offset[t] = off_type'(-t);
            end
            1: begin
               plan_terms = 3'd3;
               plan_offset[0] = off_type'(-127);
               plan_offset[1] = off_type'(0);
               plan_offset[2] = off_type'(-50);
            end
            2: plan_terms = 3'd0;
            3: plan_terms = 3'd1;
            4: begin
               plan_terms = 3'd7;
               plan_offset = '{off_type'(-128), off_type'(127), off_type'(-127), off_type'(0),
                               off_type'(1), off_type'(-1), off_type'(85)};
            end
            default: ;
         endcase
         write_settings();
         calm = (phase == 2);
         repeat ($urandom_range(5, 9)) begin
            if ($urandom_range(9) == 0)
               send_scramble();
            else
               send_document();
         end
         settle();
         phase++;
      end
      calm = 1'b0;

      $display("Sent %0d requests over %0d register settings; %0d document counts checked.",
               requests_sent, phase + 1, freqs_checked);
      $display("Included a full generation wrap with table sweep and a saturating document.");
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
